// ===== rtl/u8w_pkg.sv =====
// Shared types and constants for the UTF-8 display width counter.
// No dependencies; used by u8w_step and utf8_display_width_counter.
`timescale 1ns / 1ps
`default_nettype none

package u8w_pkg;

    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int CP_BITS    = 21;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] END_ESC   = 8'h6D;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    typedef enum logic [2:0] {
        MODE_TEXT  = 3'b001,
        MODE_ESC   = 3'b010,
        MODE_MULTI = 3'b100
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t                mode;
        logic [1:0]                bytes_left;
        logic [CP_BITS-1:0]        cp_acc;
        logic [COUNT_BITS-1:0]     width_total;
    } scan_state_t;

endpackage

`default_nettype wire

// ===== rtl/u8w_step.sv =====
// Next-state logic for one text byte: escape skipping, UTF-8 assembly,
// wide-range classification and the saturating width add. Uses u8w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8w_step (
    input  wire logic [7:0]                        text_byte,
    input  wire u8w_pkg::scan_state_t              cur,
    output u8w_pkg::scan_state_t                   nxt,
    output logic                                   emit,
    output logic [u8w_pkg::COUNT_BITS-1:0]         result
);

    logic                               add_en;
    logic [u8w_pkg::CP_BITS-1:0]        cp_sel;
    logic [u8w_pkg::CP_BITS-1:0]        cp_shift;
    logic                               wide;
    logic [u8w_pkg::COUNT_BITS:0]       sum;
    logic [u8w_pkg::COUNT_BITS-1:0]     width_sum;

    assign cp_shift = {cur.cp_acc[u8w_pkg::CP_BITS-7:0], text_byte[5:0]};

    always_comb
    begin
        wide = ((cp_sel >= 21'h02600) && (cp_sel <= 21'h027BF)) ||
               ((cp_sel >= 21'h02300) && (cp_sel <= 21'h023FF)) ||
               ((cp_sel >= 21'h02B00) && (cp_sel <= 21'h02BFF)) ||
               ((cp_sel >= 21'h1F000) && (cp_sel <= 21'h1FFFF)) ||
               ((cp_sel >= 21'h02E80) && (cp_sel <= 21'h09FFF)) ||
               ((cp_sel >= 21'h0AC00) && (cp_sel <= 21'h0D7A3)) ||
               ((cp_sel >= 21'h0F900) && (cp_sel <= 21'h0FAFF)) ||
               ((cp_sel >= 21'h0FF01) && (cp_sel <= 21'h0FF60)) ||
               ((cp_sel >= 21'h0FFE0) && (cp_sel <= 21'h0FFE6));
    end

    // saturating add of 1 or 2 columns
    always_comb
    begin
        sum = {1'b0, cur.width_total} + (wide ? (u8w_pkg::COUNT_BITS+1)'(2)
                                              : (u8w_pkg::COUNT_BITS+1)'(1));
        if (!add_en)
            width_sum = cur.width_total;
        else if (sum[u8w_pkg::COUNT_BITS])
            width_sum = '1;
        else
            width_sum = sum[u8w_pkg::COUNT_BITS-1:0];
    end

    always_comb
    begin
        nxt    = cur;
        emit   = 1'b0;
        add_en = 1'b0;
        cp_sel = cur.cp_acc;

        if (text_byte == u8w_pkg::TERM_BYTE)
        begin
            // classify a partial sequence, then emit and clear
            add_en          = (cur.mode == u8w_pkg::MODE_MULTI);
            emit            = 1'b1;
            nxt.mode        = u8w_pkg::MODE_TEXT;
            nxt.bytes_left  = '0;
            nxt.cp_acc      = '0;
        end
        else
        begin
            case (cur.mode)
                u8w_pkg::MODE_ESC:
                begin
                    if (text_byte == u8w_pkg::END_ESC)
                        nxt.mode = u8w_pkg::MODE_TEXT;
                end
                u8w_pkg::MODE_MULTI:
                begin
                    nxt.bytes_left = cur.bytes_left - 2'd1;
                    cp_sel         = cp_shift;
                    if (cur.bytes_left == 2'd1)
                    begin
                        add_en     = 1'b1;
                        nxt.cp_acc = '0;
                        nxt.mode   = u8w_pkg::MODE_TEXT;
                    end
                    else
                    begin
                        nxt.cp_acc = cp_shift;
                    end
                end
                default:
                begin
                    nxt.mode = u8w_pkg::MODE_TEXT;
                    if (text_byte == u8w_pkg::ESC_BYTE)
                    begin
                        nxt.mode = u8w_pkg::MODE_ESC;
                    end
                    else if (!text_byte[7])
                    begin
                        add_en = 1'b1;
                        cp_sel = {13'd0, text_byte};
                    end
                    else if (text_byte[7:5] == 3'b110)
                    begin
                        nxt.cp_acc     = {16'd0, text_byte[4:0]};
                        nxt.bytes_left = 2'd1;
                        nxt.mode       = u8w_pkg::MODE_MULTI;
                    end
                    else if (text_byte[7:4] == 4'b1110)
                    begin
                        nxt.cp_acc     = {17'd0, text_byte[3:0]};
                        nxt.bytes_left = 2'd2;
                        nxt.mode       = u8w_pkg::MODE_MULTI;
                    end
                    else if (text_byte[7:3] == 5'b11110)
                    begin
                        nxt.cp_acc     = {18'd0, text_byte[2:0]};
                        nxt.bytes_left = 2'd3;
                        nxt.mode       = u8w_pkg::MODE_MULTI;
                    end
                    else
                    begin
                        // invalid lead byte
                        add_en = 1'b1;
                        cp_sel = '0;
                    end
                end
            endcase
        end

        nxt.width_total = emit ? '0 : width_sum;
    end

    assign result = width_sum;

endmodule

`default_nettype wire

// ===== rtl/utf8_display_width_counter.sv =====
// UTF-8 display width counter: top level with input register, scan state
// and result register. Depends on u8w_pkg and u8w_step.
//
// Usage:
//   Text bytes enter on the s_ channel, one byte per beat; a zero byte
//   ends the string. ESC opens an escape run that is skipped up to and
//   including 'm'. Other bytes are decoded as UTF-8; each code point adds
//   two columns in the wide ranges (CJK, Hangul, fullwidth, symbols,
//   emoji) and one column otherwise.
//   On the terminator one beat leaves on the m_ channel carrying the
//   column count, saturated at its maximum; all scan state then clears.
//   Path: a terminator passes through two register stages, the input
//   byte register and the result register, before it shows on m_tdata.
//   Throughput: one byte per cycle while no result waits on m_tready;
//   the scan state register between input and result updates per byte.
//   Stall: while m_tvalid is high and m_tready low, the result holds and
//   the input register holds its byte; s_tready drops once that register
//   is full, so nothing is lost.
//   Reset (rst_n low, asynchronous) empties both registers and returns
//   the scanner to plain text with a width of zero.
`timescale 1ns / 1ps
`default_nettype none

module utf8_display_width_counter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] text_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [u8w_pkg::OUT_BITS-1:0]        m_tdata    // [15:0] display_width
);

    logic                                   in_valid_reg;
    logic [7:0]                             in_byte_reg;
    u8w_pkg::scan_state_t                   state_reg;
    u8w_pkg::scan_state_t                   state_next;
    logic                                   out_valid_reg;
    logic [u8w_pkg::OUT_BITS-1:0]           out_data_reg;
    logic                                   emit;
    logic [u8w_pkg::COUNT_BITS-1:0]         result;
    logic                                   advance;

    // a byte in the input register moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    u8w_step u_step (
        .text_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.mode        <= u8w_pkg::MODE_TEXT;
            state_reg.bytes_left  <= '0;
            state_reg.cp_acc      <= '0;
            state_reg.width_total <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                state_reg <= state_next;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (advance && emit)
            out_data_reg <= u8w_pkg::OUT_BITS'(result);
    end

endmodule

`default_nettype wire
